// ===== design/cwdf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwdf_pkg
// Types, codes and saturating arithmetic shared by the ladder filter modules.
// ----------------------------------------------------------------------------
package cwdf_pkg;

  localparam int MaxSec = 64;
  localparam int SecW   = 6;
  localparam int WaveW  = 32;
  localparam int CoefW  = 18;
  localparam int NumCoef = 7;

  // coefficient selectors
  localparam logic [2:0] CS_G11   = 3'd0;
  localparam logic [2:0] CS_G12   = 3'd1;
  localparam logic [2:0] CS_G2    = 3'd2;
  localparam logic [2:0] CS_G3    = 3'd3;
  localparam logic [2:0] CS_G41   = 3'd4;
  localparam logic [2:0] CS_G42   = 3'd5;
  localparam logic [2:0] CS_SCALE = 3'd6;

  // commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_LOAD   = 1'b1;

  // configuration register indexes
  localparam logic CFG_INPUT_GAIN = 1'b0;
  localparam logic CFG_HELIC_GAIN = 1'b1;

  localparam logic [WaveW-1:0] WMAX = 32'h7FFF_FFFF;
  localparam logic [WaveW-1:0] WMIN = 32'h8000_0000;

  typedef logic [WaveW-1:0] wave_t;
  typedef logic [CoefW-1:0] coef_t;
  typedef logic [SecW-1:0]  sec_t;

  typedef struct packed {
    logic        command;
    logic [5:0]  section_index;
    logic [2:0]  coef_select;
    logic [31:0] coef_value;
    logic [23:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [5:0]  section_out;
    logic [31:0] displacement;
    logic        last_section;
  } out_item_t;

  // one backward-sweep record per section
  typedef struct packed {
    wave_t a21;
    wave_t b44;
    wave_t b30;
    wave_t b33;
    wave_t b20;
    wave_t b23;
    wave_t b14;
  } scr_t;

  typedef enum logic [5:0] {
    ST_IDLE,
    ST_D0, ST_D1,
    ST_B0, ST_B1, ST_B2, ST_B3, ST_B4, ST_B5, ST_B6, ST_B7, ST_B8, ST_B9,
    ST_B10, ST_B11, ST_B12,
    ST_F0, ST_F1, ST_F2, ST_F3, ST_F4, ST_F5, ST_F6, ST_F7, ST_F8, ST_F9,
    ST_F10, ST_F11, ST_F12, ST_F13, ST_F14, ST_F15, ST_F16, ST_F17, ST_F18,
    ST_F19, ST_F20,
    ST_H0, ST_H1, ST_H2, ST_H3,
    ST_CLR
  } step_t;

  typedef struct packed {
    step_t step;
    sec_t  sec;
    logic  first;
    logic  last;
    logic  start;
    logic  load;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

  function automatic wave_t sadd(input wave_t a, input wave_t b);
    logic [WaveW:0] s;
    begin
      s = {a[WaveW-1], a} + {b[WaveW-1], b};
      if (s[WaveW] != s[WaveW-1]) return s[WaveW] ? WMIN : WMAX;
      return s[WaveW-1:0];
    end
  endfunction

  function automatic wave_t ssub(input wave_t a, input wave_t b);
    logic [WaveW:0] s;
    begin
      s = {a[WaveW-1], a} - {b[WaveW-1], b};
      if (s[WaveW] != s[WaveW-1]) return s[WaveW] ? WMIN : WMAX;
      return s[WaveW-1:0];
    end
  endfunction

  function automatic wave_t sneg(input wave_t a);
    begin
      if (a == WMIN) return WMAX;
      return wave_t'(-a);
    end
  endfunction

  // floor shift of a 65-bit product, then saturate to a wave
  function automatic wave_t mfin(input logic signed [64:0] p, input logic [4:0] sh);
    logic signed [64:0] q;
    begin
      q = p >>> sh;
      if (q[64:WaveW-1] == {(66-WaveW){q[64]}}) return q[WaveW-1:0];
      return q[64] ? WMIN : WMAX;
    end
  endfunction

endpackage

// ===== design/cwdf_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwdf_ctrl
// Step sequencer: clears the tables after reset, then walks the backward
// sweep, forward sweep and helicotrema update, one step per cycle unless output stalls.
// ----------------------------------------------------------------------------
module cwdf_ctrl #(
  parameter int NUM_SECTIONS = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_command,
  output logic           in_ready,
  input  cwdf_pkg::sts_t sts,
  output cwdf_pkg::cmd_t cmd
);

  localparam cwdf_pkg::sec_t LastSec = cwdf_pkg::SecW'(NUM_SECTIONS - 1);

  cwdf_pkg::step_t state_r, state_nxt;
  cwdf_pkg::sec_t  sec_r, sec_nxt;
  logic            accept;

  assign accept = in_valid && (state_r == cwdf_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    sec_nxt   = sec_r;
    case (state_r)
      cwdf_pkg::ST_CLR: begin
        if (sec_r == LastSec) begin
          state_nxt = cwdf_pkg::ST_IDLE;
          sec_nxt   = '0;
        end else begin
          sec_nxt = sec_r + 1'b1;
        end
      end
      cwdf_pkg::ST_IDLE: begin
        if (accept && in_command == cwdf_pkg::CMD_SAMPLE) state_nxt = cwdf_pkg::ST_D0;
      end
      cwdf_pkg::ST_D1: begin
        state_nxt = cwdf_pkg::ST_B0;
        sec_nxt   = LastSec;
      end
      cwdf_pkg::ST_B12: begin
        if (sec_r == '0) begin
          state_nxt = cwdf_pkg::ST_F0;
        end else begin
          state_nxt = cwdf_pkg::ST_B0;
          sec_nxt   = sec_r - 1'b1;
        end
      end
      cwdf_pkg::ST_F20: begin
        if (!sts.out_busy) begin
          if (sec_r == LastSec) begin
            state_nxt = cwdf_pkg::ST_H0;
          end else begin
            state_nxt = cwdf_pkg::ST_F0;
            sec_nxt   = sec_r + 1'b1;
          end
        end
      end
      cwdf_pkg::ST_H3: begin
        state_nxt = cwdf_pkg::ST_IDLE;
        sec_nxt   = '0;
      end
      default: begin
        state_nxt = cwdf_pkg::step_t'(state_r + 6'd1);
      end
    endcase
  end

  always_comb begin
    in_ready  = (state_r == cwdf_pkg::ST_IDLE);
    cmd.step  = state_r;
    cmd.sec   = sec_r;
    cmd.first = (sec_r == '0);
    cmd.last  = (sec_r == LastSec);
    cmd.start = accept && (in_command == cwdf_pkg::CMD_SAMPLE);
    cmd.load  = accept && (in_command == cwdf_pkg::CMD_LOAD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cwdf_pkg::ST_CLR;
      sec_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sec_r   <= sec_nxt;
    end
  end

endmodule

// ===== design/cwdf_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwdf_dp
// Datapath: coefficient and wave memories, scratch memory, one multiplier,
// saturating adders and the output register.
// ----------------------------------------------------------------------------
module cwdf_dp #(
  parameter int NUM_SECTIONS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cwdf_pkg::cmd_t      cmd,
  output cwdf_pkg::sts_t      sts,
  input  cwdf_pkg::in_item_t  in_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_wdata,
  output logic                out_valid,
  input  logic                out_ready,
  output cwdf_pkg::out_item_t out_data
);

  localparam int MaxSec = cwdf_pkg::MaxSec;

  // memories
  cwdf_pkg::coef_t mem_g11 [MaxSec];
  cwdf_pkg::coef_t mem_g12 [MaxSec];
  cwdf_pkg::coef_t mem_g2  [MaxSec];
  cwdf_pkg::coef_t mem_g3  [MaxSec];
  cwdf_pkg::coef_t mem_g41 [MaxSec];
  cwdf_pkg::coef_t mem_g42 [MaxSec];
  cwdf_pkg::wave_t mem_scl [MaxSec];
  cwdf_pkg::wave_t mem_ser [MaxSec];
  cwdf_pkg::wave_t mem_shu [MaxSec];
  cwdf_pkg::wave_t mem_ind [MaxSec];
  cwdf_pkg::wave_t mem_mem [MaxSec];
  cwdf_pkg::scr_t  mem_scr [MaxSec];

  // registered read data
  cwdf_pkg::coef_t g11_q, g12_q, g2_q, g3_q, g41_q, g42_q;
  cwdf_pkg::wave_t scl_q, ser_q, shu_q, ind_q, mem_q;
  cwdf_pkg::scr_t  scr_q;

  // read views
  cwdf_pkg::coef_t g11, g12, g2, g3, g41, g42;
  cwdf_pkg::wave_t scl, ser, shu, ind, wmem;

  assign g11  = g11_q;
  assign g12  = g12_q;
  assign g2   = g2_q;
  assign g3   = g3_q;
  assign g41  = g41_q;
  assign g42  = g42_q;
  assign scl  = scl_q;
  assign ser  = ser_q;
  assign shu  = shu_q;
  assign ind  = ind_q;
  assign wmem = mem_q;

  // configuration
  logic [31:0]     gain_r;
  cwdf_pkg::coef_t hg_r;

  // working registers
  cwdf_pkg::wave_t a21_r, b44_r, b30_r, b33_r, b20_r, b23_r, b14_r, t_r, m_r;
  cwdf_pkg::wave_t drive_r, a14_r, a10_r, b11_r, b12_r, u_r, b22_r, b32_r;
  cwdf_pkg::wave_t u2_r, b21_r, u3_r, b31_r, a40_r, b41_r, ni_r, b42_r, b43_r;
  cwdf_pkg::wave_t x_r, b13_r, helic_r;
  logic [23:0]     sample_r;
  logic signed [64:0] p_r;

  logic            out_valid_r;
  cwdf_pkg::out_item_t out_data_r;

  logic               mul_en;
  logic [32:0]        ma;
  logic [31:0]        mb;
  cwdf_pkg::wave_t    b14_nxt;
  logic               load_ok;
  logic               emit;

  assign sts.out_busy = out_valid_r && !out_ready;
  assign emit         = (cmd.step == cwdf_pkg::ST_F20) && !sts.out_busy;
  assign b14_nxt      = cwdf_pkg::ssub(ser, b23_r);
  assign load_ok      = cmd.load &&
                        ({1'b0, in_data.section_index} < 7'(NUM_SECTIONS));

  // multiplier operand selection
  always_comb begin
    mul_en = 1'b1;
    ma     = '0;
    mb     = '0;
    case (cmd.step)
      cwdf_pkg::ST_D0:  begin ma = {1'b0, gain_r}; mb = {{8{sample_r[23]}}, sample_r}; end
      cwdf_pkg::ST_B3:  begin ma = 33'(g3);  mb = t_r;   end
      cwdf_pkg::ST_B8:  begin ma = 33'(g2);  mb = t_r;   end
      cwdf_pkg::ST_F3:  begin ma = 33'(g11); mb = a10_r; end
      cwdf_pkg::ST_F4:  begin ma = 33'(g12); mb = a10_r; end
      cwdf_pkg::ST_F12: begin ma = 33'(g41); mb = a40_r; end
      cwdf_pkg::ST_F13: begin ma = 33'(g42); mb = a40_r; end
      cwdf_pkg::ST_F19: begin ma = {x_r[31], x_r}; mb = scl; end
      cwdf_pkg::ST_H1:  begin ma = 33'(hg_r); mb = t_r; end
      default:          mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mul_en) p_r <= $signed(ma) * $signed(mb);
  end

  // memory writes and registered reads; the clearing pass zeroes one entry a cycle
  always_ff @(posedge clk) begin
    if (cmd.step == cwdf_pkg::ST_CLR) begin
      mem_g11[cmd.sec] <= '0;
      mem_g12[cmd.sec] <= '0;
      mem_g2[cmd.sec]  <= '0;
      mem_g3[cmd.sec]  <= '0;
      mem_g41[cmd.sec] <= '0;
      mem_g42[cmd.sec] <= '0;
      mem_scl[cmd.sec] <= '0;
      mem_ser[cmd.sec] <= '0;
      mem_shu[cmd.sec] <= '0;
      mem_ind[cmd.sec] <= '0;
      mem_mem[cmd.sec] <= '0;
    end else begin
      if (load_ok) begin
        case (in_data.coef_select)
          cwdf_pkg::CS_G11:   mem_g11[in_data.section_index] <= in_data.coef_value[17:0];
          cwdf_pkg::CS_G12:   mem_g12[in_data.section_index] <= in_data.coef_value[17:0];
          cwdf_pkg::CS_G2:    mem_g2[in_data.section_index]  <= in_data.coef_value[17:0];
          cwdf_pkg::CS_G3:    mem_g3[in_data.section_index]  <= in_data.coef_value[17:0];
          cwdf_pkg::CS_G41:   mem_g41[in_data.section_index] <= in_data.coef_value[17:0];
          cwdf_pkg::CS_G42:   mem_g42[in_data.section_index] <= in_data.coef_value[17:0];
          cwdf_pkg::CS_SCALE: mem_scl[in_data.section_index] <= in_data.coef_value;
          default: ;
        endcase
      end
      if (emit) begin
        mem_ser[cmd.sec] <= b13_r;
        mem_shu[cmd.sec] <= b32_r;
        mem_ind[cmd.sec] <= b42_r;
        mem_mem[cmd.sec] <= b43_r;
      end
    end
    if (cmd.step == cwdf_pkg::ST_B12) begin
      mem_scr[cmd.sec] <= '{a21_r, b44_r, b30_r, b33_r, b20_r, b23_r, b14_nxt};
    end
    g11_q <= mem_g11[cmd.sec];
    g12_q <= mem_g12[cmd.sec];
    g2_q  <= mem_g2[cmd.sec];
    g3_q  <= mem_g3[cmd.sec];
    g41_q <= mem_g41[cmd.sec];
    g42_q <= mem_g42[cmd.sec];
    scl_q <= mem_scl[cmd.sec];
    ser_q <= mem_ser[cmd.sec];
    shu_q <= mem_shu[cmd.sec];
    ind_q <= mem_ind[cmd.sec];
    mem_q <= mem_mem[cmd.sec];
    scr_q <= mem_scr[cmd.sec];
  end

  // configuration registers and helicotrema store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r  <= '0;
      hg_r    <= '0;
      helic_r <= '0;
    end else begin
      if (cfg_we && cfg_index == cwdf_pkg::CFG_INPUT_GAIN) gain_r <= cfg_wdata;
      if (cfg_we && cfg_index == cwdf_pkg::CFG_HELIC_GAIN) hg_r <= cfg_wdata[17:0];
      if (cmd.step == cwdf_pkg::ST_H3) begin
        helic_r <= cwdf_pkg::sneg(cwdf_pkg::sadd(cwdf_pkg::sneg(m_r), b21_r));
      end
    end
  end

  // arithmetic steps
  always_ff @(posedge clk) begin
    if (cmd.start) sample_r <= in_data.sample;
    case (cmd.step)
      cwdf_pkg::ST_D1:  drive_r <= cwdf_pkg::mfin(p_r, 5'd16);
      cwdf_pkg::ST_B1: begin
        a21_r <= cmd.last ? helic_r : cwdf_pkg::sneg(b14_r);
        b44_r <= cwdf_pkg::ssub(ind, wmem);
      end
      cwdf_pkg::ST_B2:  t_r   <= cwdf_pkg::ssub(shu, b44_r);
      cwdf_pkg::ST_B4:  m_r   <= cwdf_pkg::mfin(p_r, 5'd18);
      cwdf_pkg::ST_B5:  b30_r <= cwdf_pkg::sneg(m_r);
      cwdf_pkg::ST_B6:  b33_r <= cwdf_pkg::sadd(shu, b30_r);
      cwdf_pkg::ST_B7:  t_r   <= cwdf_pkg::ssub(b33_r, a21_r);
      cwdf_pkg::ST_B9:  m_r   <= cwdf_pkg::mfin(p_r, 5'd18);
      cwdf_pkg::ST_B10: b20_r <= cwdf_pkg::sneg(m_r);
      cwdf_pkg::ST_B11: b23_r <= cwdf_pkg::sadd(b33_r, b20_r);
      cwdf_pkg::ST_B12: b14_r <= b14_nxt;
      cwdf_pkg::ST_F1:  a14_r <= cmd.first ? cwdf_pkg::sadd(drive_r, scr_q.b14)
                                           : cwdf_pkg::sneg(b21_r);
      cwdf_pkg::ST_F2:  a10_r <= cwdf_pkg::ssub(a14_r, scr_q.b14);
      cwdf_pkg::ST_F4:  m_r   <= cwdf_pkg::mfin(p_r, 5'd18);
      cwdf_pkg::ST_F5: begin
        b11_r <= cwdf_pkg::ssub(scr_q.b23, m_r);
        m_r   <= cwdf_pkg::mfin(p_r, 5'd18);
      end
      cwdf_pkg::ST_F6:  b12_r <= cwdf_pkg::sneg(m_r);
      cwdf_pkg::ST_F7: begin
        u_r   <= cwdf_pkg::sadd(b11_r, b12_r);
        b22_r <= cwdf_pkg::sadd(b11_r, scr_q.b20);
      end
      cwdf_pkg::ST_F8: begin
        b13_r <= cwdf_pkg::sneg(cwdf_pkg::sadd(u_r, a14_r));
        b32_r <= cwdf_pkg::sadd(b22_r, scr_q.b30);
        u2_r  <= cwdf_pkg::sadd(b22_r, scr_q.b33);
      end
      cwdf_pkg::ST_F9: begin
        b21_r <= cwdf_pkg::ssub(u2_r, scr_q.a21);
        u3_r  <= cwdf_pkg::sadd(b32_r, shu);
      end
      cwdf_pkg::ST_F10: b31_r <= cwdf_pkg::ssub(u3_r, scr_q.b44);
      cwdf_pkg::ST_F11: a40_r <= cwdf_pkg::ssub(b31_r, scr_q.b44);
      cwdf_pkg::ST_F13: m_r   <= cwdf_pkg::mfin(p_r, 5'd18);
      cwdf_pkg::ST_F14: begin
        b41_r <= cwdf_pkg::sneg(m_r);
        m_r   <= cwdf_pkg::mfin(p_r, 5'd18);
        ni_r  <= cwdf_pkg::sneg(ind);
      end
      cwdf_pkg::ST_F15: b42_r <= cwdf_pkg::ssub(ni_r, m_r);
      cwdf_pkg::ST_F16: u_r   <= cwdf_pkg::sadd(b41_r, b42_r);
      cwdf_pkg::ST_F17: b43_r <= cwdf_pkg::sneg(cwdf_pkg::sadd(u_r, b31_r));
      cwdf_pkg::ST_F18: x_r   <= cwdf_pkg::sadd(b43_r, wmem);
      cwdf_pkg::ST_H0:  t_r   <= cwdf_pkg::ssub(b21_r, helic_r);
      cwdf_pkg::ST_H2:  m_r   <= cwdf_pkg::mfin(p_r, 5'd18);
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.section_out  <= cmd.sec;
      out_data_r.displacement <= cwdf_pkg::mfin(p_r, 5'd15);
      out_data_r.last_section <= cmd.last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/cochlear_wave_digital_filter.sv =====
`timescale 1ns / 1ps
// A sample transaction yields its first result at the last forward step of section 0.
// A new sample is accepted only once the previous one has finished its helicotrema update;
//   the single shared multiplier and one step per cycle, barring output stalls, set this pace.
// A load transaction gives no result.
// Reset (rst_n low, synchronous) clears control, configuration and the helicotrema
//   store, then a clearing pass over the N sections zeroes tables and wave stores, input held off.
// ----------------------------------------------------------------------------
// cochlear_wave_digital_filter
// Ladder wave digital filter: backward sweep, forward sweep and helicotrema
// update per sample, one displacement per section out.
// ----------------------------------------------------------------------------
module cochlear_wave_digital_filter #(
  parameter int NUM_SECTIONS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_ready,
  input  cwdf_pkg::in_item_t  in_data,
  // result channel
  output logic                out_valid,
  input  logic                out_ready,
  output cwdf_pkg::out_item_t out_data,
  // configuration port
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_wdata
);

  // Command and status between sequencer and datapath
  cwdf_pkg::cmd_t cmd;
  cwdf_pkg::sts_t sts;

  // Sequencer: holds the step and section counters; stalls the last forward
  // step of a section while the output register is still occupied.
  cwdf_ctrl #(
    .NUM_SECTIONS(NUM_SECTIONS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_data.command),
    .in_ready   (in_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Datapath: memories, multiplier, saturating adders, output register
  cwdf_dp #(
    .NUM_SECTIONS(NUM_SECTIONS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== design/cwdf_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cwdf_chk
// Port-level checks of the ladder filter, bound to the top level.
// ----------------------------------------------------------------------------
module cwdf_chk #(
  parameter int NUM_SECTIONS = 64
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input cwdf_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input cwdf_pkg::out_item_t out_data,
  input logic                cfg_we,
  input logic                cfg_index,
  input logic [31:0]         cfg_wdata
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.command == cwdf_pkg::CMD_SAMPLE |=> !in_ready)
    else $error("input taken during sweep");

  a_mid_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_section |-> !in_ready)
    else $error("input ready before sweep finished");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_section |->
      out_data.section_out == cwdf_pkg::SecW'(NUM_SECTIONS - 1))
    else $error("last flag on wrong section");

endmodule

bind cochlear_wave_digital_filter cwdf_chk #(.NUM_SECTIONS(NUM_SECTIONS)) u_chk (.*);
